@@ hdl/contiguous_block_allocator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the block allocator checker
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator same-cycle check failed");

// next-cycle implication, checked outside reset
`define CBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator next-cycle check failed");

`endif

@@ hdl/cba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_pkg
// shared constants, word types and codes of the first-fit block allocator
// ----------------------------------------------------------------------------
package cba_pkg;

  // heap geometry
  localparam int NUM_BLOCKS  = 64;
  localparam int BLOCK_BYTES = 32;
  localparam int HEAP_BYTES  = NUM_BLOCKS * BLOCK_BYTES;
  localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);
  localparam int IDX_W       = $clog2(NUM_BLOCKS);
  localparam int CNT_W       = $clog2(NUM_BLOCKS + 1);

  // field widths
  localparam int SIZE_W  = 16;
  localparam int OFF_W   = 11;
  localparam int BYTES_W = 12;

  // operation codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO     = 2'd1,
    STAT_NOSPACE  = 2'd2,
    STAT_NOTSTART = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_RDLEN,
    S_FREE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              op;
    logic [SIZE_W-1:0] size_bytes;
    logic [OFF_W-1:0]  release_offset;
  } req_word_t;

  typedef struct packed {
    status_t            status;
    logic [OFF_W-1:0]   alloc_offset;
    logic [BYTES_W-1:0] free_bytes;
    logic [BYTES_W-1:0] used_bytes;
  } rsp_word_t;

endpackage

@@ hdl/contiguous_block_allocator_unit.sv @@
// allocate: a request rejected at decode goes straight to the result; else the
// first-fit scan reads one bit of the block map per cycle, then the mark pass
// clears one block per cycle; a failed scan runs to the end of the map.
// release: a reject goes to the result; else free the run, one block per cycle.
// one word in flight; the next request is taken the cycle after a result loads.
// reset (rst, synchronous): every block free, no live runs, output empty.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_block_allocator_unit
// first-fit allocator over a heap of fixed-size blocks, bit-serial map scan
// ----------------------------------------------------------------------------
module contiguous_block_allocator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  cba_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output cba_pkg::rsp_word_t rsp
);

  localparam int CNT_W = cba_pkg::CNT_W;
  localparam int IDX_W = cba_pkg::IDX_W;
  localparam int NEED_W = cba_pkg::SIZE_W + 1;

  cba_pkg::state_t  state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] run_len;
  logic [CNT_W-1:0] need;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] free_count;
  logic [IDX_W-1:0] start_idx;
  logic [cba_pkg::NUM_BLOCKS-1:0] free_map;
  logic [cba_pkg::NUM_BLOCKS-1:0] start_map;
  cba_pkg::status_t res_status;
  logic [cba_pkg::OFF_W-1:0] res_offset;

  // run length store, read at the requested release index
  logic [CNT_W-1:0] len_mem [cba_pkg::NUM_BLOCKS];
  logic [CNT_W-1:0] len_rd;
  logic             len_we;

  logic req_acc;
  logic rsp_load;

  // request decode
  logic [NEED_W-1:0]         need_w;
  logic                      size_zero;
  logic                      need_big;
  logic [cba_pkg::OFF_W-1:0] rel_idx_full;
  logic [IDX_W-1:0]          rel_idx;
  logic                      rel_ok;

  assign need_w = NEED_W'(req.size_bytes >> cba_pkg::BLK_SHIFT)
                + NEED_W'((req.size_bytes % cba_pkg::BLOCK_BYTES) != 0);
  assign size_zero = (req.size_bytes == '0);
  assign need_big  = (need_w > NEED_W'(cba_pkg::NUM_BLOCKS));
  assign rel_idx_full = req.release_offset >> cba_pkg::BLK_SHIFT;
  assign rel_idx      = rel_idx_full[IDX_W-1:0];
  assign rel_ok = ((req.release_offset % cba_pkg::BLOCK_BYTES) == 0)
               && (rel_idx_full < cba_pkg::OFF_W'(cba_pkg::NUM_BLOCKS))
               && !free_map[rel_idx] && start_map[rel_idx];

  // scan and free pass decode
  logic             scan_end;
  logic             scan_free;
  logic             scan_hit;
  logic [IDX_W-1:0] hit_start;
  logic             free_done;

  assign scan_end  = (cnt == CNT_W'(cba_pkg::NUM_BLOCKS));
  assign scan_free = free_map[cnt[IDX_W-1:0]];
  assign scan_hit  = !scan_end && scan_free && (CNT_W'(run_len + 1'b1) == need);
  assign hit_start = (run_len == '0) ? cnt[IDX_W-1:0] : start_idx;
  assign free_done = (rem == '0) || scan_end;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    req_ready  = (state == cba_pkg::S_IDLE);
    req_acc    = req_valid && req_ready;
    rsp_load   = 1'b0;
    len_we     = 1'b0;
    unique case (state)
      cba_pkg::S_IDLE: begin
        if (req_acc) begin
          if (req.op == cba_pkg::OP_ALLOC) begin
            state_next = (size_zero || need_big) ? cba_pkg::S_EMIT : cba_pkg::S_SCAN;
          end else begin
            state_next = rel_ok ? cba_pkg::S_RDLEN : cba_pkg::S_EMIT;
          end
        end
      end
      cba_pkg::S_SCAN: begin
        if (scan_end) begin
          state_next = cba_pkg::S_EMIT;
        end else if (scan_hit) begin
          len_we     = 1'b1;
          state_next = cba_pkg::S_MARK;
        end
      end
      cba_pkg::S_MARK: begin
        if (rem == CNT_W'(1)) state_next = cba_pkg::S_EMIT;
      end
      cba_pkg::S_RDLEN: begin
        state_next = cba_pkg::S_FREE;
      end
      cba_pkg::S_FREE: begin
        if (free_done) state_next = cba_pkg::S_EMIT;
      end
      cba_pkg::S_EMIT: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = cba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cba_pkg::S_IDLE;
      end
    endcase
  end

  // run length store
  always_ff @(posedge clk) begin
    if (len_we) len_mem[hit_start] <= need;
    len_rd <= len_mem[rel_idx];
  end

  // block map, counters and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      free_map   <= '1;
      start_map  <= '0;
      free_count <= CNT_W'(cba_pkg::NUM_BLOCKS);
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp.status       <= res_status;
        rsp.alloc_offset <= res_offset;
        rsp.free_bytes   <= cba_pkg::BYTES_W'(free_count) << cba_pkg::BLK_SHIFT;
        rsp.used_bytes   <= cba_pkg::BYTES_W'(CNT_W'(cba_pkg::NUM_BLOCKS) - free_count)
                            << cba_pkg::BLK_SHIFT;
        rsp_valid        <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        // latch the request and its early checks
        cba_pkg::S_IDLE: begin
          if (req_acc) begin
            res_offset <= '0;
            cnt        <= '0;
            run_len    <= '0;
            if (req.op == cba_pkg::OP_ALLOC) begin
              need <= need_w[CNT_W-1:0];
              if (size_zero) begin
                res_status <= cba_pkg::STAT_ZERO;
              end else if (need_big) begin
                res_status <= cba_pkg::STAT_NOSPACE;
              end else begin
                res_status <= cba_pkg::STAT_OK;
              end
            end else begin
              start_idx  <= rel_idx;
              res_status <= rel_ok ? cba_pkg::STAT_OK : cba_pkg::STAT_NOTSTART;
              if (rel_ok) start_map[rel_idx] <= 1'b0;
            end
          end
        end
        // first-fit scan, one block per cycle
        cba_pkg::S_SCAN: begin
          if (scan_end) begin
            res_status <= cba_pkg::STAT_NOSPACE;
          end else if (scan_hit) begin
            start_idx  <= hit_start;
            cnt        <= CNT_W'(hit_start);
            rem        <= need;
            free_count <= free_count - need;
            start_map[hit_start] <= 1'b1;
            res_offset <= cba_pkg::OFF_W'(hit_start) << cba_pkg::BLK_SHIFT;
          end else begin
            cnt <= CNT_W'(cnt + 1'b1);
            if (scan_free) begin
              if (run_len == '0) start_idx <= cnt[IDX_W-1:0];
              run_len <= CNT_W'(run_len + 1'b1);
            end else begin
              run_len <= '0;
            end
          end
        end
        // mark the found run used
        cba_pkg::S_MARK: begin
          free_map[cnt[IDX_W-1:0]] <= 1'b0;
          cnt <= CNT_W'(cnt + 1'b1);
          rem <= rem - 1'b1;
        end
        // run length read back
        cba_pkg::S_RDLEN: begin
          rem <= len_rd;
          cnt <= CNT_W'(start_idx);
        end
        // free the released run, one block per cycle
        cba_pkg::S_FREE: begin
          if (!free_done) begin
            if (!free_map[cnt[IDX_W-1:0]]) begin
              free_map[cnt[IDX_W-1:0]] <= 1'b1;
              free_count <= CNT_W'(free_count + 1'b1);
            end
            cnt <= CNT_W'(cnt + 1'b1);
            rem <= rem - 1'b1;
          end
        end
        cba_pkg::S_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/cba_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_checker
// port-level checks of the block allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "contiguous_block_allocator_unit_assert.svh"

module cba_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input cba_pkg::req_word_t req,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input cba_pkg::rsp_word_t rsp
);

  localparam int SUM_W = cba_pkg::BYTES_W + 1;

  // a stalled result word holds
  `CBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

  // free and used bytes always cover the whole heap
  `CBA_ASSERT_NOW(a_bytes_sum, rsp_valid,
    (SUM_W'(rsp.free_bytes) + SUM_W'(rsp.used_bytes)) == SUM_W'(cba_pkg::HEAP_BYTES))

  // offsets land on block boundaries
  `CBA_ASSERT_NOW(a_off_align, rsp_valid,
    (rsp.alloc_offset % cba_pkg::BLOCK_BYTES) == 0)

  // failed steps report a zero offset
  `CBA_ASSERT_NOW(a_fail_zero, rsp_valid && (rsp.status != cba_pkg::STAT_OK),
    rsp.alloc_offset == '0)

endmodule

bind contiguous_block_allocator_unit cba_checker u_cba_checker (.*);
